>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

>>> rtl/mts_pkg.sv
// Shared constants and types of the min tracking stack.
`default_nettype none

package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> rtl/mts_if.sv
// Request and response channel interfaces of the min tracking stack.
`default_nettype none

interface mts_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  operation;
	logic signed [mts_pkg::VALUE_W-1:0]    push_value;

	modport source(output valid, operation, push_value, input ready);
	modport sink(input valid, operation, push_value, output ready);
endinterface

interface mts_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mts_pkg::VALUE_W-1:0]    top_value;
	logic signed [mts_pkg::VALUE_W-1:0]    min_value;
	logic                                  is_empty;
	logic [mts_pkg::COUNT_W-1:0]           entry_count;
	mts_pkg::status_t                      status;

	modport source(output valid, top_value, min_value, is_empty, entry_count, status,
		input ready);
	modport sink(input valid, top_value, min_value, is_empty, entry_count, status,
		output ready);
endinterface

`default_nettype wire

>>> rtl/mts_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/min_tracking_stack_core.sv
// Min tracking stack: LIFO of signed words that reports the running minimum.
//
// req carries one word per operation: operation 0 pushes push_value, 1 pops.
// rsp returns exactly one word per request, describing the stack afterwards:
// top_value, min_value (both 0 when empty), is_empty, entry_count and status
// (ok, push refused on full, pop refused on empty).
// The top entry lives in registers; entries below it sit in one RAM of
// STACK_DEPTH words, each holding the value and the minimum up to it.
// Push, a refused operation or a pop down to an empty stack: the response is
// registered and valid in the cycle after acceptance, one request per cycle
// while rsp.ready is high. Pop with two or more entries: the new top is read
// from the RAM (registered read) and loaded into the top registers in
// ST_POP_RD, which raises the response; requests wait while in ST_POP_RD.
// A response waiting on a stalled rsp.ready blocks further requests; a request
// is taken in the same cycle the pending response leaves.
// Reset (arst_n low) empties the stack at once; RAM contents need no clearing.
`default_nettype none

module min_tracking_stack_core (
	input wire logic   clk,
	input wire logic   arst_n,
	mts_req_if.sink    req,
	mts_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_POP_RD = 2'b10
	} state_t;

	localparam int RAM_W = 2 * mts_pkg::VALUE_W;

	state_t                                state_q;
	logic [mts_pkg::CNT_W-1:0]             count_q;
	logic                                  out_valid_q;
	mts_pkg::status_t                      status_q;
	logic signed [mts_pkg::VALUE_W-1:0]    top_val_q;
	logic signed [mts_pkg::VALUE_W-1:0]    top_min_q;

	logic                                  accept;
	logic                                  is_push;
	logic                                  cnt_zero;
	logic                                  cnt_one;
	logic                                  cnt_full;
	logic signed [mts_pkg::VALUE_W-1:0]    new_min;
	logic                                  ram_we;
	logic                                  ram_re;
	logic [mts_pkg::ADDR_W-1:0]            ram_waddr;
	logic [mts_pkg::ADDR_W-1:0]            ram_raddr;
	logic [RAM_W-1:0]                      ram_rdata;
	logic signed [mts_pkg::VALUE_W-1:0]    rd_val;
	logic signed [mts_pkg::VALUE_W-1:0]    rd_min;

	assign accept   = req.valid && req.ready;
	assign is_push  = !req.operation;
	assign cnt_zero = (count_q == '0);
	assign cnt_one  = (count_q == mts_pkg::CNT_W'(1));
	assign cnt_full = (count_q == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));

	assign new_min = (!cnt_zero && (top_min_q < req.push_value)) ? top_min_q
		: req.push_value;

	// Push spills the current top into the RAM; pop refills it from the entry below.
	assign ram_we    = accept && is_push && !cnt_full && !cnt_zero;
	assign ram_waddr = mts_pkg::ADDR_W'(count_q - mts_pkg::CNT_W'(1));
	assign ram_re    = accept && !is_push && !cnt_zero && !cnt_one;
	assign ram_raddr = mts_pkg::ADDR_W'(count_q - mts_pkg::CNT_W'(2));

	assign rd_val = ram_rdata[RAM_W-1:mts_pkg::VALUE_W];
	assign rd_min = ram_rdata[mts_pkg::VALUE_W-1:0];

	mts_ram #(
		.WIDTH(RAM_W),
		.DEPTH(mts_pkg::STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({top_val_q, top_min_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_push && !cnt_full) begin
							count_q <= count_q + mts_pkg::CNT_W'(1);
						end else if (!is_push && !cnt_zero) begin
							count_q <= count_q - mts_pkg::CNT_W'(1);
						end
						state_q     <= ram_re ? ST_POP_RD : ST_IDLE;
						out_valid_q <= !ram_re;
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_POP_RD: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_POP_RD) begin
			top_val_q <= rd_val;
			top_min_q <= rd_min;
			status_q  <= mts_pkg::STATUS_OK;
		end else if (accept) begin
			if (is_push) begin
				if (cnt_full) begin
					status_q <= mts_pkg::STATUS_FULL;
				end else begin
					top_val_q <= req.push_value;
					top_min_q <= new_min;
					status_q  <= mts_pkg::STATUS_OK;
				end
			end else begin
				status_q <= cnt_zero ? mts_pkg::STATUS_EMPTY : mts_pkg::STATUS_OK;
			end
		end
	end

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);

	assign rsp.valid       = out_valid_q;
	assign rsp.is_empty    = cnt_zero;
	assign rsp.top_value   = cnt_zero ? '0 : top_val_q;
	assign rsp.min_value   = cnt_zero ? '0 : top_min_q;
	assign rsp.entry_count = mts_pkg::COUNT_W'(count_q);
	assign rsp.status      = status_q;

endmodule

`default_nettype wire

>>> rtl/mts_checker.sv
// Port-level checker of the min tracking stack and its bind.
`default_nettype none
`include "assert_macros.svh"

module mts_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic signed [mts_pkg::VALUE_W-1:0] top_value,
	input wire logic signed [mts_pkg::VALUE_W-1:0] min_value,
	input wire logic                               is_empty,
	input wire logic [mts_pkg::COUNT_W-1:0]        entry_count,
	input wire mts_pkg::status_t                   status
);

	`ASSERT_NEXT(a_rsp_holds, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_IMPLY(a_empty_count, clk, arst_n, rsp_valid, is_empty == (entry_count == '0))
	`ASSERT_IMPLY(a_empty_zero, clk, arst_n, rsp_valid && is_empty, (top_value == '0) && (min_value == '0))
	`ASSERT_IMPLY(a_min_le_top, clk, arst_n, rsp_valid && !is_empty, min_value <= top_value)
	`ASSERT_IMPLY(a_refused_pop, clk, arst_n, rsp_valid && (status == mts_pkg::STATUS_EMPTY), is_empty)

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.top_value   (rsp.top_value),
	.min_value   (rsp.min_value),
	.is_empty    (rsp.is_empty),
	.entry_count (rsp.entry_count),
	.status      (rsp.status)
);

`default_nettype wire

>>> verif/mts_tb_pkg.sv
`timescale 1ns / 1ps
// Operation codes shared by the min tracking stack testbench files.
package mts_tb_pkg;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} stack_op_t;

endpackage

>>> verif/mts_result_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every stack response word and compares it with the block's output.
module mts_result_checker (
	input wire logic clk,
	input wire logic arst_n,
	mts_req_if       req,
	mts_rsp_if       rsp,
	output int       fail_count,
	output int       pending,
	output int       checked,
	output int       full_refusals,
	output int       empty_refusals
);
	import mts_pkg::*;
	import mts_tb_pkg::*;

	typedef struct packed {
		logic signed [VALUE_W-1:0] top_value;
		logic signed [VALUE_W-1:0] min_value;
		logic                      is_empty;
		logic [COUNT_W-1:0]        entry_count;
		status_t                   status;
	} stack_view_t;

	// each slot keeps its value and the minimum from the bottom up to it
	logic signed [VALUE_W-1:0] value_slots [STACK_DEPTH];
	logic signed [VALUE_W-1:0] floor_mins [STACK_DEPTH];
	int unsigned               depth;
	stack_view_t               expected_views [$];

	function automatic stack_view_t apply_op(input stack_op_t op,
			input logic signed [VALUE_W-1:0] value);
		stack_view_t               view;
		logic signed [VALUE_W-1:0] running_min;
		view.status = STATUS_OK;
		if (op == OP_PUSH) begin
			if (depth >= STACK_DEPTH) begin
				view.status = STATUS_FULL;
			end else begin
				running_min = value;
				if (depth > 0 && floor_mins[depth-1] < value)
					running_min = floor_mins[depth-1];
				value_slots[depth] = value;
				floor_mins[depth]  = running_min;
				depth++;
			end
		end else if (depth == 0) begin
			view.status = STATUS_EMPTY;
		end else begin
			depth--;
		end
		view.is_empty    = (depth == 0);
		view.top_value   = (depth > 0) ? value_slots[depth-1] : '0;
		view.min_value   = (depth > 0) ? floor_mins[depth-1] : '0;
		view.entry_count = COUNT_W'(depth);
		return view;
	endfunction

	task automatic compare_field(input string field, input longint expected, input longint actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, got %0d", field, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_view_t want;
		if (!arst_n) begin
			depth = 0;
			expected_views.delete();
		end else begin
			if (req.valid && req.ready) begin
				want = apply_op(stack_op_t'(req.operation), req.push_value);
				if (want.status == STATUS_FULL)
					full_refusals++;
				if (want.status == STATUS_EMPTY)
					empty_refusals++;
				expected_views.insert(expected_views.size(), want);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_views.size() == 0) begin
					$error("response word with no request outstanding");
					fail_count++;
				end else begin
					want = expected_views.pop_front();
					compare_field("top_value", want.top_value, rsp.top_value);
					compare_field("min_value", want.min_value, rsp.min_value);
					compare_field("is_empty", want.is_empty, rsp.is_empty);
					compare_field("entry_count", want.entry_count, rsp.entry_count);
					compare_field("status", want.status, rsp.status);
					checked++;
				end
			end
		end
		pending = expected_views.size();
	end

endmodule

>>> verif/tb_min_tracking_stack_core.sv
`timescale 1ns / 1ps
// Testbench top for the min tracking stack: clock, reset, stimulus and verdict.
module tb_min_tracking_stack_core;
	import mts_pkg::*;
	import mts_tb_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int ITEMS_PER_PHASE = 270;
	localparam int HOLD_CYCLES     = 80;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_requests      = 0;
	int holds_served       = 0;
	int words_sent         = 0;
	int push_words         = 0;
	int pop_words          = 0;
	int stack_fill         = 0;
	int quiet_cycles       = 0;

	int fail_count;
	int pending;
	int checked;
	int full_refusals;
	int empty_refusals;

	mts_req_if req_ch();
	mts_rsp_if rsp_ch();

	min_tracking_stack_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mts_result_checker result_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked),
		.full_refusals  (full_refusals),
		.empty_refusals (empty_refusals)
	);

	always #5 clk = ~clk;

	// response side: random stalls, plus a long hold-off whenever one is requested
	initial begin : receiver
		int hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("tb_min_tracking_stack_core failed");
			$finish;
		end
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int offset;
		offset = int'($urandom_range(16)) - 8;
		case ($urandom_range(9))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2, 3: return offset;
			default: return $urandom;
		endcase
	endfunction

	// offers one word and returns at the edge where it is taken; valid stays up
	task automatic send_word(input stack_op_t op, input logic signed [VALUE_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.push_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		if (op == OP_PUSH) begin
			push_words++;
			if (stack_fill < STACK_DEPTH)
				stack_fill++;
		end else begin
			pop_words++;
			if (stack_fill > 0)
				stack_fill--;
		end
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		wait (checked == words_sent);
	endtask

	task automatic run_random_phase(input int quota);
		int                        first;
		int                        run_len;
		logic signed [VALUE_W-1:0] walk;
		logic                      rising;
		first = words_sent;
		while (words_sent - first < quota) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					repeat ($urandom_range(30, 5))
						send_word(($urandom_range(99) < 55) ? OP_PUSH : OP_POP, pick_value());
				end
				4, 5: begin
					// fill to the top, then knock on it
					while (stack_fill < STACK_DEPTH)
						send_word(OP_PUSH, pick_value());
					repeat ($urandom_range(3, 1))
						send_word(OP_PUSH, pick_value());
				end
				6, 7: begin
					while (stack_fill > 0)
						send_word(OP_POP, pick_value());
					repeat ($urandom_range(3, 1))
						send_word(OP_POP, pick_value());
				end
				default: begin
					// monotonic run so the minimum either follows every push or never moves
					run_len = $urandom_range(12, 2);
					walk    = pick_value();
					rising  = 1'($urandom_range(1));
					repeat (run_len) begin
						send_word(OP_PUSH, walk);
						walk = rising ? walk + $urandom_range(1000) : walk - $urandom_range(1000);
					end
					repeat ($urandom_range(run_len, 1))
						send_word(OP_POP, pick_value());
				end
			endcase
		end
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_PUSH;
		req_ch.push_value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: refusal on empty, extremes of the value and the min chain
		send_word(OP_POP, 32'sh7fffffff);
		send_word(OP_PUSH, 32'sd5);
		send_word(OP_PUSH, 32'sd7);
		send_word(OP_PUSH, -32'sd3);
		send_word(OP_PUSH, 32'sh7fffffff);
		send_word(OP_PUSH, 32'sh80000000);
		send_word(OP_PUSH, 32'sd0);
		send_word(OP_PUSH, -32'sd1);
		send_word(OP_POP, 32'sh80000000);
		send_word(OP_POP, -32'sd1);
		send_word(OP_POP, 32'sd0);
		send_word(OP_POP, 32'sd0);
		send_word(OP_POP, 32'sd0);
		send_word(OP_POP, 32'sd0);
		send_word(OP_POP, 32'sd0);
		send_word(OP_POP, 32'sh55555555);
		send_word(OP_PUSH, 32'sh80000000);
		send_word(OP_PUSH, 32'sh80000000);
		send_word(OP_POP, 32'shaaaaaaaa);
		send_word(OP_POP, 32'sd0);
		wait_all_results();

		// no idling; a long receiver hold-off backs the block up first
		hold_requests++;
		run_random_phase(ITEMS_PER_PHASE);
		wait_all_results();

		sender_idle_pct = 61;
		run_random_phase(ITEMS_PER_PHASE);
		wait_all_results();

		sender_idle_pct    = 0;
		receiver_stall_pct = 61;
		run_random_phase(ITEMS_PER_PHASE);
		wait_all_results();

		sender_idle_pct    = 35;
		receiver_stall_pct = 35;
		run_random_phase(ITEMS_PER_PHASE);
		wait_all_results();

		repeat (8) @(posedge clk);
		$display("run covered %0d words (%0d push, %0d pop) over four idling mixes",
			words_sent, push_words, pop_words);
		$display("%0d pushes refused when full, %0d pops refused when empty, %0d words compared",
			full_refusals, empty_refusals, checked);
		if (fail_count == 0 && pending == 0 && checked == words_sent) begin
			$display("tb_min_tracking_stack_core passed");
		end else begin
			$display("tb_min_tracking_stack_core failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_if.sv
rtl/mts_ram.sv
rtl/min_tracking_stack_core.sv
rtl/mts_checker.sv
verif/mts_tb_pkg.sv
verif/mts_result_checker.sv
verif/tb_min_tracking_stack_core.sv
